>>> sv/cfq_pkg.sv
// cfq_pkg: shared types, request and status codes for the circular fifo queue
// used by cfq_ptr and circular_fifo_queue; no dependencies
package cfq_pkg;

    localparam int DEPTH_DEF  = 16;
    localparam int WORD_W     = 32;
    localparam int COUNT_W    = 5;

    localparam logic [2:0] REQ_PUSH     = 3'd0;
    localparam logic [2:0] REQ_POP      = 3'd1;
    localparam logic [2:0] REQ_PEEK_OLD = 3'd2;
    localparam logic [2:0] REQ_PEEK_NEW = 3'd3;
    localparam logic [2:0] REQ_CLEAR    = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [2:0]               req_type;
        logic signed [WORD_W-1:0] push_value;
    } t_req;

    typedef struct packed {
        logic signed [WORD_W-1:0] read_value;
        logic [1:0]               status;
        logic [COUNT_W-1:0]       entry_count;
        logic                     is_full;
        logic                     is_empty;
    } t_rsp;

    // per-request decision from the pointer block
    typedef struct packed {
        logic               wr_en;
        logic               rd_en;
        logic [1:0]         status;
        logic [COUNT_W-1:0] entry_count;
        logic               is_full;
        logic               is_empty;
    } t_op_info;

endpackage

>>> sv/cfq_ram.sv
// cfq_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module cfq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/cfq_ptr.sv
// cfq_ptr: head, tail and occupancy registers with the per-request decode
// depends on cfq_pkg
module cfq_ptr #(
    parameter int DEPTH = cfq_pkg::DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_fire,
    input  logic [2:0]               i_req_type,
    output cfq_pkg::t_op_info        o_info,
    output logic [$clog2(DEPTH)-1:0] o_wr_addr,
    output logic [$clog2(DEPTH)-1:0] o_rd_addr
);
    import cfq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_occ,  n_occ;
    logic [AW-1:0] head_inc, tail_inc;
    logic          occ_zero, occ_full;

    assign head_inc = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
    assign tail_inc = (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;
    assign occ_zero = (r_occ == '0);
    assign occ_full = (r_occ == FULL_CNT);

    always_comb begin
        n_head         = r_head;
        n_tail         = r_tail;
        n_occ          = r_occ;
        o_info.wr_en   = 1'b0;
        o_info.rd_en   = 1'b0;
        o_info.status  = ST_OK;
        o_wr_addr      = tail_inc;
        o_rd_addr      = r_head;
        case (i_req_type)
            REQ_PUSH: begin
                if (occ_full) begin
                    o_info.status = ST_FULL;
                end else begin
                    o_info.wr_en = 1'b1;
                    n_tail       = tail_inc;
                    n_occ        = r_occ + 1'b1;
                end
            end
            REQ_POP: begin
                if (occ_zero) begin
                    o_info.status = ST_EMPTY;
                end else begin
                    o_info.rd_en = 1'b1;
                    n_occ        = r_occ - 1'b1;
                    // last entry gone: pointers go back to their reset places
                    if (r_occ == CW'(1)) begin
                        n_head = '0;
                        n_tail = LAST_IDX;
                    end else begin
                        n_head = head_inc;
                    end
                end
            end
            REQ_PEEK_OLD: begin
                if (occ_zero) begin
                    o_info.status = ST_EMPTY;
                end else begin
                    o_info.rd_en = 1'b1;
                end
            end
            REQ_PEEK_NEW: begin
                o_rd_addr = r_tail;
                if (occ_zero) begin
                    o_info.status = ST_EMPTY;
                end else begin
                    o_info.rd_en = 1'b1;
                end
            end
            REQ_CLEAR: begin
                n_head = '0;
                n_tail = LAST_IDX;
                n_occ  = '0;
            end
            default: begin
            end
        endcase
        // count and flags describe the queue after this request
        o_info.entry_count = COUNT_W'(n_occ);
        o_info.is_full     = (n_occ == FULL_CNT);
        o_info.is_empty    = (n_occ == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= LAST_IDX;
            r_occ  <= '0;
        end else if (i_fire) begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_occ  <= n_occ;
        end
    end

endmodule

>>> sv/circular_fifo_queue.sv
// circular_fifo_queue: ring-buffer fifo of signed words with push, pop, peeks and clear
// depends on cfq_pkg, cfq_ptr and cfq_ram
//
// usage
//   input channel: i_in_valid / o_in_stall carry one request transaction
//     (req_type, push_value); a transaction moves on a rising edge with
//     valid high and stall low
//   output channel: o_out_valid / i_out_stall carry exactly one result
//     transaction per request, in request order
//   results: push, clear and every rejected or unknown request show their
//     result in the cycle after acceptance; pops and peeks pass through
//     S_READ first, since the word comes out of the slot ram on a registered read
//   throughput: one request per cycle for non-reading requests while
//     i_out_stall stays low; successful pops and peeks hold o_in_stall high in S_READ
//   reset: i_rst_n low empties the queue (count 0, head 0, tail at the last
//     slot); slot contents are not cleared and are never read before written
//   stall: a result waits in the output register while i_out_stall is high;
//     a new request is still taken when the waiting result leaves that cycle,
//     otherwise o_in_stall is raised
module circular_fifo_queue #(
    parameter int DEPTH = cfq_pkg::DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  cfq_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output cfq_pkg::t_rsp o_out_data
);
    import cfq_pkg::*;

    localparam int AW = $clog2(DEPTH);

    // control sequence: idle takes requests, read waits for the ram word
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state           r_state;
    t_op_info         info;
    t_op_info         r_pend;
    t_rsp             r_out;
    logic             r_out_valid;
    logic             in_fire;
    logic             out_take;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;
    logic [WORD_W-1:0] rd_data;

    // output register may be refilled on the edge its result leaves
    assign out_take   = r_out_valid && !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && (!r_out_valid || out_take));
    assign in_fire    = i_in_valid && !o_in_stall;

    cfq_ptr #(
        .DEPTH (DEPTH)
    ) u_ptr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (in_fire),
        .i_req_type (i_in_data.req_type),
        .o_info     (info),
        .o_wr_addr  (wr_addr),
        .o_rd_addr  (rd_addr)
    );

    // slot storage, written on accepted pushes, read on accepted pops and peeks
    cfq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (in_fire && info.wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_in_data.push_value),
        .i_rd_en   (in_fire && info.rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // control state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (out_take) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        if (info.rd_en) begin
                            r_state <= S_READ;
                        end else begin
                            r_out_valid <= 1'b1;
                        end
                    end
                end
                S_READ: begin
                    // ram word is ready, output register is free here
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_out.read_value  <= rd_data;
            r_out.status      <= r_pend.status;
            r_out.entry_count <= r_pend.entry_count;
            r_out.is_full     <= r_pend.is_full;
            r_out.is_empty    <= r_pend.is_empty;
        end else if (in_fire) begin
            r_pend            <= info;
            // no word read: value reads as zero
            r_out.read_value  <= '0;
            r_out.status      <= info.status;
            r_out.entry_count <= info.entry_count;
            r_out.is_full     <= info.is_full;
            r_out.is_empty    <= info.is_empty;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
